/* src/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// shared widths, codes and word types for the matrix to quaternion converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int IN_W      = 16;
  localparam int NUM_W     = IN_W + 1;
  // unsigned width of a positive radicand, signed width while it is formed
  localparam int RAD_W     = ((FRAC_BITS > IN_W) ? FRAC_BITS : IN_W) + 2;
  localparam int RADS_W    = RAD_W + 1;
  localparam int SQ_RAW    = RAD_W + FRAC_BITS;
  localparam int SQ_W      = SQ_RAW + (SQ_RAW % 2);
  localparam int ROOT_W    = SQ_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int S_W       = ROOT_W + 1;
  localparam int DV_W      = NUM_W + FRAC_BITS + 1;
  localparam int QW        = 16;
  localparam int Q_MAX     = 32767;

  localparam logic signed [RADS_W-1:0] ONE_RAD =
    {{(RADS_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

  typedef struct packed {
    logic signed [IN_W-1:0] r00;
    logic signed [IN_W-1:0] r01;
    logic signed [IN_W-1:0] r02;
    logic signed [IN_W-1:0] r10;
    logic signed [IN_W-1:0] r11;
    logic signed [IN_W-1:0] r12;
    logic signed [IN_W-1:0] r20;
    logic signed [IN_W-1:0] r21;
    logic signed [IN_W-1:0] r22;
  } mat_t;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic [1:0]         branch_taken;
    logic               degenerate;
  } quat_t;

  typedef struct packed {
    logic [1:0]              br;
    logic                    degen;
    logic signed [NUM_W-1:0] n0;
    logic signed [NUM_W-1:0] n1;
    logic signed [NUM_W-1:0] n2;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [SQ_W-1:0]   v;
    side_t             side;
  } sq_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QW-1:0]    dq;
    logic [S_W-1:0]   s;
    logic             ovf;
    logic             neg;
  } dv_t;

  typedef struct packed {
    logic [1:0]         br;
    logic               degen;
    logic signed [15:0] diag;
  } tag_t;

endpackage

`default_nettype wire

/* src/rmq_front.sv */
// ----------------------------------------------------------------------------
// rmq_front
// branch choice, radicand with clamp, and off-diagonal numerators
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmq_front
  import rmq_pkg::*;
(
  input  wire logic clk,
  input  wire logic en,
  input  wire mat_t mat,
  output sq_t       sq
);

  logic signed [RADS_W-1:0] a, b, c, tr, rad_s;
  logic [RAD_W-1:0]         rad;
  logic [1:0]               br;
  logic                     degen;
  side_t                    side;

  always_comb begin
    a  = RADS_W'(mat.r00);
    b  = RADS_W'(mat.r11);
    c  = RADS_W'(mat.r22);
    tr = a + b + c;
    priority if (tr > 0) begin
      br    = BR_TRACE;
      rad_s = tr + ONE_RAD;
    end else if (a > b && a > c) begin
      br    = BR_X;
      rad_s = ONE_RAD + a - b - c;
    end else if (b > c) begin
      br    = BR_Y;
      rad_s = ONE_RAD + b - a - c;
    end else begin
      br    = BR_Z;
      rad_s = ONE_RAD + c - a - b;
    end
    degen = rad_s[RADS_W-1] || (rad_s == '0);
    rad   = degen ? RAD_W'(1) : rad_s[RAD_W-1:0];

    side.br    = br;
    side.degen = degen;
    unique case (br)
      BR_TRACE: begin
        side.n0 = NUM_W'(mat.r12) - NUM_W'(mat.r21);
        side.n1 = NUM_W'(mat.r20) - NUM_W'(mat.r02);
        side.n2 = NUM_W'(mat.r01) - NUM_W'(mat.r10);
      end
      BR_X: begin
        side.n0 = NUM_W'(mat.r12) - NUM_W'(mat.r21);
        side.n1 = NUM_W'(mat.r01) + NUM_W'(mat.r10);
        side.n2 = NUM_W'(mat.r02) + NUM_W'(mat.r20);
      end
      BR_Y: begin
        side.n0 = NUM_W'(mat.r20) - NUM_W'(mat.r02);
        side.n1 = NUM_W'(mat.r01) + NUM_W'(mat.r10);
        side.n2 = NUM_W'(mat.r12) + NUM_W'(mat.r21);
      end
      default: begin
        side.n0 = NUM_W'(mat.r01) - NUM_W'(mat.r10);
        side.n1 = NUM_W'(mat.r02) + NUM_W'(mat.r20);
        side.n2 = NUM_W'(mat.r12) + NUM_W'(mat.r21);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq.rem  <= '0;
      sq.root <= '0;
      sq.v    <= SQ_W'(rad) << FRAC_BITS;
      sq.side <= side;
    end
  end

endmodule

`default_nettype wire

/* src/rmq_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// rmq_sqrt_cell
// one restoring square root step: one root bit per cell
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmq_sqrt_cell
  import rmq_pkg::*;
(
  input  wire logic clk,
  input  wire logic en,
  input  wire sq_t  d_in,
  output sq_t       d_out
);

  logic [REM_W+1:0] cur, sub, diff;
  logic             ge;

  always_comb begin
    cur  = {d_in.rem, d_in.v[SQ_W-1 -: 2]};
    sub  = {2'b00, d_in.root, 2'b01};
    ge   = cur >= sub;
    diff = cur - sub;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out.rem  <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
      d_out.root <= {d_in.root[ROOT_W-2:0], ge};
      d_out.v    <= d_in.v << 2;
      d_out.side <= d_in.side;
    end
  end

endmodule

`default_nettype wire

/* src/rmq_div_cell.sv */
// ----------------------------------------------------------------------------
// rmq_div_cell
// one restoring division step: one quotient bit per cell
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmq_div_cell
  import rmq_pkg::*;
(
  input  wire logic clk,
  input  wire logic en,
  input  wire dv_t  d_in,
  output dv_t       d_out
);

  logic [REM_W:0] cur, dvs, diff;
  logic           ge;

  always_comb begin
    cur  = {d_in.rem, d_in.dq[QW-1]};
    dvs  = {{(REM_W+1-S_W){1'b0}}, d_in.s};
    ge   = cur >= dvs;
    diff = cur - dvs;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out.rem <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
      d_out.dq  <= {d_in.dq[QW-2:0], ge};
      d_out.s   <= d_in.s;
      d_out.ovf <= d_in.ovf;
      d_out.neg <= d_in.neg;
    end
  end

endmodule

`default_nettype wire

/* src/rotation_matrix_to_quaternion.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// 3x3 rotation matrix to quaternion, trace method with four branches, Q2.14
// ----------------------------------------------------------------------------
// throughput: one word per cycle while the output is not stalled; the root chain and
//   divider chains are fully pipelined, one bit per cell, so every stage advances each
//   cycle; a stalled output freezes the whole pipe, output register included
// reset: synchronous, clears the valid chain only; payload is not reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rotation_matrix_to_quaternion
  import rmq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  mat_valid,
  output logic       mat_stall,
  input  wire mat_t  mat,
  output logic       quat_valid,
  input  wire logic  quat_stall,
  output quat_t      quat
);

  // front, root cells, divider set-up, divider cells
  localparam int NST = 1 + ROOT_W + 1 + QW;

  logic           en;
  logic [NST-1:0] vld;

  sq_t  sq_chain [ROOT_W+1];
  dv_t  dv_chain [3][QW+1];
  tag_t tag_chain [QW+1];

  // the pipe moves whenever the output register can take a word
  assign en        = !(quat_valid && quat_stall);
  assign mat_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      quat_valid <= 1'b0;
    end else if (en) begin
      vld        <= {vld[NST-2:0], mat_valid};
      quat_valid <= vld[NST-1];
    end
  end

  // branch select and radicand
  rmq_front u_front (
    .clk (clk),
    .en  (en),
    .mat (mat),
    .sq  (sq_chain[0])
  );

  // integer square root, one result bit per cell
  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    rmq_sqrt_cell u_cell (
      .clk   (clk),
      .en    (en),
      .d_in  (sq_chain[i]),
      .d_out (sq_chain[i+1])
    );
  end

  // divider set-up: rounded dividend, divisor S = 2*root, overflow check
  sq_t                     sq_end;
  logic [ROOT_W-1:0]       half;
  logic [S_W-1:0]          s;
  logic signed [NUM_W-1:0] num [3];
  logic [NUM_W-1:0]        mag [3];
  logic [DV_W-1:0]         dvd [3];
  logic [DV_W-1:0]         hi  [3];
  logic                    ovf [3];
  logic signed [15:0]      diag;

  always_comb begin
    sq_end = sq_chain[ROOT_W];
    s      = {sq_end.root, 1'b0};
    half   = sq_end.root >> 1;
    diag   = (int'(half) > Q_MAX) ? 16'sh7fff : 16'(half);
    num[0] = sq_end.side.n0;
    num[1] = sq_end.side.n1;
    num[2] = sq_end.side.n2;
    for (int l = 0; l < 3; l++) begin
      mag[l] = num[l][NUM_W-1] ? NUM_W'(-num[l]) : NUM_W'(num[l]);
      dvd[l] = (DV_W'(mag[l]) << FRAC_BITS) + DV_W'(sq_end.root);
      hi[l]  = dvd[l] >> QW;
      // quotient of 2^QW or more saturates whatever its sign
      ovf[l] = hi[l] >= DV_W'(s);
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_setup
    always_ff @(posedge clk) begin
      if (en) begin
        dv_chain[l][0].rem <= ovf[l] ? '0 : hi[l][REM_W-1:0];
        dv_chain[l][0].dq  <= dvd[l][QW-1:0];
        dv_chain[l][0].s   <= s;
        dv_chain[l][0].ovf <= ovf[l];
        dv_chain[l][0].neg <= num[l][NUM_W-1];
      end
    end
  end

  // three divider lanes side by side, one quotient bit per cell
  for (genvar l = 0; l < 3; l++) begin : g_lane
    for (genvar i = 0; i < QW; i++) begin : g_div
      rmq_div_cell u_cell (
        .clk   (clk),
        .en    (en),
        .d_in  (dv_chain[l][i]),
        .d_out (dv_chain[l][i+1])
      );
    end
  end

  // branch tag rides alongside the divider cells
  always_ff @(posedge clk) begin
    if (en) begin
      tag_chain[0].br    <= sq_end.side.br;
      tag_chain[0].degen <= sq_end.side.degen;
      tag_chain[0].diag  <= diag;
      for (int i = 0; i < QW; i++) begin
        tag_chain[i+1] <= tag_chain[i];
      end
    end
  end

  // signed saturation and placement of the components
  logic signed [15:0] res [3];
  logic [QW:0]        qext [3];
  tag_t               tag_end;
  quat_t              quat_next;

  always_comb begin
    tag_end = tag_chain[QW];
    for (int l = 0; l < 3; l++) begin
      qext[l] = {1'b0, dv_chain[l][QW].dq};
      if (dv_chain[l][QW].neg) begin
        res[l] = (dv_chain[l][QW].ovf || qext[l] > (QW+1)'(Q_MAX + 1)) ?
                 16'sh8000 : 16'(-qext[l]);
      end else begin
        res[l] = (dv_chain[l][QW].ovf || qext[l] > (QW+1)'(Q_MAX)) ?
                 16'sh7fff : 16'(qext[l]);
      end
    end
    quat_next.branch_taken = tag_end.br;
    quat_next.degenerate   = tag_end.degen;
    unique case (tag_end.br)
      BR_TRACE: begin
        quat_next.quat_w = tag_end.diag;
        quat_next.quat_x = res[0];
        quat_next.quat_y = res[1];
        quat_next.quat_z = res[2];
      end
      BR_X: begin
        quat_next.quat_x = tag_end.diag;
        quat_next.quat_w = res[0];
        quat_next.quat_y = res[1];
        quat_next.quat_z = res[2];
      end
      BR_Y: begin
        quat_next.quat_y = tag_end.diag;
        quat_next.quat_w = res[0];
        quat_next.quat_x = res[1];
        quat_next.quat_z = res[2];
      end
      default: begin
        quat_next.quat_z = tag_end.diag;
        quat_next.quat_w = res[0];
        quat_next.quat_x = res[1];
        quat_next.quat_y = res[2];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quat <= quat_next;
    end
  end

`ifndef SYNTHESIS
  // a positive trace always gives a radicand above one
  a_trace_not_degen : assert property (@(posedge clk) disable iff (rst)
    quat_valid |-> !(quat.degenerate && quat.branch_taken == BR_TRACE))
    else $error("degenerate word on the trace branch");

  // the S/4 component is never negative
  a_w_nonneg : assert property (@(posedge clk) disable iff (rst)
    (quat_valid && quat.branch_taken == BR_TRACE) |-> !quat.quat_w[15])
    else $error("negative w on the trace branch");

  a_x_nonneg : assert property (@(posedge clk) disable iff (rst)
    (quat_valid && quat.branch_taken == BR_X) |-> !quat.quat_x[15])
    else $error("negative x on the x branch");

  // the pipe is empty straight after reset
  a_empty_after_reset : assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !quat_valid)
    else $error("output word straight after reset");
`endif

endmodule

`default_nettype wire
